/* hdl/position_pnl_tracker_macros.svh */
// assertion macros for the position and profit tracker
// used by the tracker top level and its shared arithmetic unit
`ifndef POSITION_PNL_TRACKER_MACROS_SVH
`define POSITION_PNL_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define PPT_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define PPT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define PPT_ASSERT_IMPLIES(label, clk, rst, a, b)
`define PPT_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* hdl/ppt_pkg.sv */
// types, constants and saturating helpers for the position and profit tracker
// no dependencies
`default_nettype none
package ppt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ACC_W       = 82;
  localparam int MUL_STEPS   = 32;

  localparam logic [47:0] MASK48  = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  localparam logic [1:0] MODE_TRADE  = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  first_owner;
    logic [3:0]  second_owner;
    logic [31:0] price;
    logic [23:0] volume;
    logic        direction;
  } ppt_req_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         owner;
    logic signed [31:0] inventory;
    logic [47:0]        average_cost;
    logic signed [63:0] realized;
    logic signed [63:0] unrealized;
    logic [31:0]        market_price;
    logic signed [63:0] total_value;
    logic               last;
  } ppt_rsp_t;

  typedef struct packed {
    logic signed [31:0] qty;
    logic [47:0]        cost;
    logic signed [63:0] prof;
  } ppt_entry_t;

  typedef enum logic [1:0] {MD_MUL, MD_MAC, MD_DIV} md_op_t;

  typedef struct packed {
    logic        start;
    md_op_t      op;
    logic [47:0] mcand;
    logic [31:0] mplier;
    logic [31:0] divisor;
  } md_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILL_START, ST_RD_WAIT, ST_LOAD, ST_F_DECIDE, ST_F_MUL1, ST_F_MUL2,
    ST_F_DIV, ST_F_RED, ST_F_BOOK, ST_F_WRITE, ST_SCAN, ST_U_DECIDE, ST_U_MUL,
    ST_TOTAL, ST_EMIT
  } ppt_state_t;

  function automatic logic [47:0] to_fix(input logic [31:0] p);
    logic [55:0] v;
    v = {24'b0, p} << FRAC_BITS;
    if (v > {8'b0, MASK48}) return MASK48;
    return v[47:0];
  endfunction

  function automatic logic [63:0] sat_signed(input logic [ACC_W-1:0] m, input logic neg);
    logic [63:0] low;
    low = m[63:0];
    if (neg) begin
      if (m >= {{(ACC_W-64){1'b0}}, S64_MIN}) return S64_MIN;
      return ~low + 64'd1;
    end
    if (m > {{(ACC_W-64){1'b0}}, S64_MAX}) return S64_MAX;
    return low;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/ppt_stream_if.sv */
// valid/ready channel carrying one payload beat of type T
// payload types come from ppt_pkg
`default_nettype none
interface ppt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/ppt_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module ppt_ram #(
  parameter int W     = 144,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/ppt_muldiv.sv */
// shared serial unit: shift-add multiply / multiply-accumulate and restoring divide
// depends on ppt_pkg and the assertion macros
`default_nettype none
`include "position_pnl_tracker_macros.svh"
module ppt_muldiv
  import ppt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire md_cmd_t          cmd,
  output      md_stat_t         stat,
  output      logic [ACC_W-1:0] result
);
  localparam logic [6:0] MUL_LAST = 7'(MUL_STEPS - 1);
  localparam logic [6:0] DIV_LAST = 7'(ACC_W - 1);

  logic             busy;
  logic             done;
  md_op_t           op_q;
  logic [6:0]       cnt;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] mc;
  logic [31:0]      mp;
  logic [31:0]      dv;
  logic [31:0]      rem;
  logic [32:0]      r2;
  logic             ge;
  logic [31:0]      rem_next;

  // remainder stays below the divisor, so rem_next always fits in 32 bits
  always_comb begin
    r2       = {rem, acc[ACC_W-1]};
    ge       = r2 >= {1'b0, dv};
    rem_next = ge ? 32'(r2 - {1'b0, dv}) : r2[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (cmd.start) begin
          busy <= 1'b1;
          op_q <= cmd.op;
          case (cmd.op)
            MD_DIV: begin
              rem <= '0;
              dv  <= cmd.divisor;
              cnt <= DIV_LAST;
            end
            default: begin
              if (cmd.op == MD_MUL) acc <= '0;
              mc  <= ACC_W'(cmd.mcand);
              mp  <= cmd.mplier;
              cnt <= MUL_LAST;
            end
          endcase
        end
      end else begin
        case (op_q)
          MD_DIV: begin
            rem <= rem_next;
            acc <= {acc[ACC_W-2:0], ge};
          end
          default: begin
            if (mp[0]) acc <= acc + mc;
            mc <= mc << 1;
            mp <= mp >> 1;
          end
        endcase
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = acc;

  `PPT_ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy)
  `PPT_ASSERT_NEXT(a_start_busy, clk, rst, cmd.start && !busy, busy)
  `PPT_ASSERT_IMPLIES(a_rem_below, clk, rst, busy && (op_q == MD_DIV), rem < dv)
endmodule
`default_nettype wire

/* hdl/position_pnl_tracker.sv */
// position_pnl_tracker: per-owner average-cost position and profit table
// trade: each side is skipped, opens, reduces or adds (two multiplies and a divide on the
// one shared serial unit); query: one result beat, without a multiply when unrealized is zero
// sample: one result beat per valid owner, empty owners passed over; beats wait on output stalls
// one item at a time; synchronous reset clears valid bits, last price and control,
// table ram is not cleared, an entry never written reads as zero
`default_nettype none
`include "position_pnl_tracker_macros.svh"
module position_pnl_tracker
  import ppt_pkg::*;
#(
  parameter int NUM_OWNERS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ppt_stream_if.sink   req,
  ppt_stream_if.source rsp
);
  localparam int AW = $clog2(NUM_OWNERS);
  localparam int CW = $clog2(NUM_OWNERS + 1);

  ppt_state_t state, state_next;

  logic [NUM_OWNERS-1:0] entry_valid;
  logic [31:0]           recent_price;
  logic                  side;
  logic [1:0]            mode_q;
  logic                  dir_q;
  logic [23:0]           vol_q;
  logic [47:0]           fx_q;
  logic [3:0]            owner1_q;
  logic [3:0]            owner2_q;
  logic [AW-1:0]         addr_q;
  logic                  hit_q;
  logic                  sell_q;
  ppt_entry_t            e;
  logic [31:0]           nv_q;
  logic [31:0]           absnv_q;
  logic                  neg_q;
  logic                  mnz_q;
  logic [63:0]           pr_q;
  logic [63:0]           unr_q;
  logic [63:0]           tot_q;
  logic [CW-1:0]         cnt;
  logic [4:0]            nres;
  logic [3:0]            owner_q;
  logic                  kind_q;
  logic                  rsp_valid;
  ppt_rsp_t              rsp_data;

  md_cmd_t          md_cmd;
  md_stat_t         md_stat;
  logic [ACC_W-1:0] md_acc;

  logic       ram_we;
  ppt_entry_t ram_rdata;

  ppt_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .cmd    (md_cmd),
    .stat   (md_stat),
    .result (md_acc)
  );

  ppt_ram #(.W($bits(ppt_entry_t)), .DEPTH(NUM_OWNERS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (e),
    .raddr (addr_q),
    .rdata (ram_rdata)
  );

  // entry arithmetic on the loaded entry
  logic [31:0]        absold;
  logic signed [32:0] dq;
  logic signed [32:0] nv_full;
  logic [31:0]        nv_sat;
  logic [31:0]        abs_nv;
  logic [31:0]        closing;
  logic               below_f;
  logic [47:0]        mag_f;
  logic [47:0]        fx_r;
  logic               below_u;
  logic [47:0]        mag_u;
  logic [3:0]         fill_owner;
  logic               fill_sell;
  logic               fill_skip;
  logic               more_valid;
  logic               emit_last;
  logic               out_free;
  logic               in_take;

  always_comb begin
    absold  = e.qty[31] ? 32'(-e.qty) : 32'(e.qty);
    dq      = sell_q ? -$signed({9'b0, vol_q}) : $signed({9'b0, vol_q});
    nv_full = {e.qty[31], e.qty} + dq;
    if (nv_full[32] != nv_full[31]) nv_sat = nv_full[32] ? S32_MIN : S32_MAX;
    else                            nv_sat = nv_full[31:0];
    abs_nv  = nv_sat[31] ? 32'(-$signed(nv_sat)) : nv_sat;
    closing = (absold < {8'b0, vol_q}) ? absold : {8'b0, vol_q};
    below_f = fx_q < e.cost;
    mag_f   = below_f ? e.cost - fx_q : fx_q - e.cost;
    fx_r    = to_fix(recent_price);
    below_u = fx_r < e.cost;
    mag_u   = below_u ? e.cost - fx_r : fx_r - e.cost;

    fill_owner = side ? owner2_q : owner1_q;
    fill_sell  = side ? !dir_q : dir_q;
    fill_skip  = (vol_q == '0) || (32'(fill_owner) >= 32'(NUM_OWNERS));

    more_valid = 1'b0;
    for (int i = 0; i < NUM_OWNERS; i++) begin
      if (entry_valid[i] && (CW'(i) > cnt)) more_valid = 1'b1;
    end
    emit_last = (kind_q == KIND_QUERY) || (nres == 5'(MAX_RESULTS - 1)) || !more_valid;
    out_free  = !rsp_valid || rsp.ready;
    in_take   = req.valid && (state == ST_IDLE);
  end

  // next state and unit commands
  always_comb begin
    state_next     = state;
    md_cmd         = '0;
    md_cmd.op      = MD_MUL;
    ram_we         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (req.data.mode)
            MODE_TRADE:  state_next = ST_FILL_START;
            MODE_QUERY:  state_next = ST_RD_WAIT;
            MODE_SAMPLE: state_next = ST_SCAN;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL_START: begin
        if (!fill_skip)      state_next = ST_RD_WAIT;
        else if (side)       state_next = ST_IDLE;
      end
      ST_RD_WAIT: state_next = ST_LOAD;
      ST_LOAD:    state_next = (mode_q == MODE_TRADE) ? ST_F_DECIDE : ST_U_DECIDE;
      ST_F_DECIDE: begin
        if (e.qty == '0) begin
          state_next = ST_F_WRITE;
        end else if (e.qty[31] == sell_q) begin
          md_cmd.start  = 1'b1;
          md_cmd.op     = MD_MUL;
          md_cmd.mcand  = e.cost;
          md_cmd.mplier = absold;
          state_next    = ST_F_MUL1;
        end else begin
          md_cmd.start  = 1'b1;
          md_cmd.op     = MD_MUL;
          md_cmd.mcand  = mag_f;
          md_cmd.mplier = closing;
          state_next    = ST_F_RED;
        end
      end
      ST_F_MUL1: begin
        if (md_stat.done) begin
          md_cmd.start  = 1'b1;
          md_cmd.op     = MD_MAC;
          md_cmd.mcand  = fx_q;
          md_cmd.mplier = {8'b0, vol_q};
          state_next    = ST_F_MUL2;
        end
      end
      ST_F_MUL2: begin
        if (md_stat.done) begin
          md_cmd.start   = 1'b1;
          md_cmd.op      = MD_DIV;
          md_cmd.divisor = absnv_q;
          state_next     = ST_F_DIV;
        end
      end
      ST_F_DIV:  if (md_stat.done) state_next = ST_F_WRITE;
      ST_F_RED:  if (md_stat.done) state_next = ST_F_BOOK;
      ST_F_BOOK: state_next = ST_F_WRITE;
      ST_F_WRITE: begin
        ram_we     = 1'b1;
        state_next = side ? ST_IDLE : ST_FILL_START;
      end
      ST_SCAN: begin
        if (cnt == CW'(NUM_OWNERS))         state_next = ST_IDLE;
        else if (entry_valid[cnt[AW-1:0]]) state_next = ST_RD_WAIT;
      end
      ST_U_DECIDE: begin
        if (e.qty == '0 || recent_price == '0 || e.cost == '0 || mag_u == '0) begin
          state_next = ST_TOTAL;
        end else begin
          md_cmd.start  = 1'b1;
          md_cmd.op     = MD_MUL;
          md_cmd.mcand  = mag_u;
          md_cmd.mplier = absold;
          state_next    = ST_U_MUL;
        end
      end
      ST_U_MUL: if (md_stat.done) state_next = ST_TOTAL;
      ST_TOTAL: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = emit_last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      recent_price <= '0;
      rsp_valid    <= 1'b0;
      side         <= 1'b0;
      cnt          <= '0;
      nres         <= '0;
    end else begin
      if (rsp_valid && rsp.ready && !(state == ST_EMIT && out_free)) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            side <= 1'b0;
            cnt  <= '0;
            nres <= '0;
            if (req.data.mode == MODE_TRADE) recent_price <= req.data.price;
          end
        end
        ST_FILL_START: if (fill_skip) side <= 1'b1;
        ST_F_WRITE: begin
          entry_valid[addr_q] <= 1'b1;
          side <= 1'b1;
        end
        ST_SCAN: begin
          if (cnt != CW'(NUM_OWNERS) && !entry_valid[cnt[AW-1:0]]) cnt <= cnt + CW'(1);
        end
        ST_EMIT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            cnt       <= cnt + CW'(1);
            nres      <= nres + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          mode_q   <= req.data.mode;
          dir_q    <= req.data.direction;
          vol_q    <= req.data.volume;
          fx_q     <= to_fix(req.data.price);
          owner1_q <= req.data.first_owner;
          owner2_q <= req.data.second_owner;
          owner_q  <= req.data.first_owner;
          addr_q   <= AW'(req.data.first_owner);
          hit_q    <= 32'(req.data.first_owner) < 32'(NUM_OWNERS);
          kind_q   <= (req.data.mode == MODE_SAMPLE) ? KIND_SAMPLE : KIND_QUERY;
        end
      end
      ST_FILL_START: begin
        addr_q <= AW'(fill_owner);
        hit_q  <= 1'b1;
        sell_q <= fill_sell;
      end
      ST_LOAD: e <= (hit_q && entry_valid[addr_q]) ? ram_rdata : '0;
      ST_F_DECIDE: begin
        if (e.qty == '0) begin
          e.qty  <= dq[31:0];
          e.cost <= fx_q;
        end else if (e.qty[31] == sell_q) begin
          nv_q    <= nv_sat;
          absnv_q <= abs_nv;
        end else begin
          nv_q  <= nv_full[31:0];
          neg_q <= e.qty[31] ? !below_f : below_f;
          mnz_q <= mag_f != '0;
        end
      end
      ST_F_DIV: begin
        if (md_stat.done) begin
          e.cost <= (md_acc > ACC_W'(MASK48)) ? MASK48 : md_acc[47:0];
          e.qty  <= nv_q;
        end
      end
      ST_F_RED: if (md_stat.done) pr_q <= sat_signed(md_acc, neg_q && mnz_q);
      ST_F_BOOK: begin
        e.prof <= sat_add(e.prof, pr_q);
        e.qty  <= nv_q;
        if (nv_q == '0)                e.cost <= '0;
        else if (e.qty[31] != nv_q[31]) e.cost <= fx_q;
      end
      ST_SCAN: begin
        addr_q  <= cnt[AW-1:0];
        hit_q   <= 1'b1;
        owner_q <= 4'(cnt);
      end
      ST_U_DECIDE: begin
        unr_q <= '0;
        neg_q <= below_u != e.qty[31];
      end
      ST_U_MUL:  if (md_stat.done) unr_q <= sat_signed(md_acc, neg_q);
      ST_TOTAL:  tot_q <= sat_add(e.prof, unr_q);
      ST_EMIT: begin
        if (out_free) begin
          rsp_data.kind         <= kind_q;
          rsp_data.owner        <= owner_q;
          rsp_data.inventory    <= e.qty;
          rsp_data.average_cost <= e.cost;
          rsp_data.realized     <= e.prof;
          rsp_data.unrealized   <= unr_q;
          rsp_data.market_price <= recent_price;
          rsp_data.total_value  <= tot_q;
          rsp_data.last         <= emit_last;
        end
      end
      default: ;
    endcase
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  `PPT_ASSERT_IMPLIES(a_start_idle, clk, rst, md_cmd.start, !md_stat.busy)
  `PPT_ASSERT_IMPLIES(a_div_nz, clk, rst, md_cmd.start && md_cmd.op == MD_DIV, |md_cmd.divisor)
  `PPT_ASSERT_IMPLIES(a_res_bound, clk, rst, state == ST_EMIT, nres < 5'(MAX_RESULTS))
  `PPT_ASSERT_NEXT(a_write_valid, clk, rst, ram_we, entry_valid[$past(addr_q)])
endmodule
`default_nettype wire
